@@ hdl/rv32i_instruction_decoder_assert.svh @@
// Assertion macros for the RV32I instruction decoder.
// Included by the top level; needs no package.
`ifndef RV32I_INSTRUCTION_DECODER_ASSERT_SVH
`define RV32I_INSTRUCTION_DECODER_ASSERT_SVH

// same-cycle implication
`define RVID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RVID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rvid_pkg.sv @@
// Shared types and codes for the RV32I instruction decoder.
// No dependencies.
package rvid_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_ALUI   = 7'h13;
  localparam logic [6:0] OP_ALUR   = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  typedef enum logic [5:0] {
    ID_ILLEGAL = 6'd0,
    ID_LUI = 6'd1, ID_AUIPC = 6'd2, ID_JAL = 6'd3, ID_JALR = 6'd4,
    ID_BEQ = 6'd5, ID_BNE = 6'd6, ID_BLT = 6'd7, ID_BGE = 6'd8,
    ID_BLTU = 6'd9, ID_BGEU = 6'd10,
    ID_LB = 6'd11, ID_LH = 6'd12, ID_LW = 6'd13, ID_LBU = 6'd14, ID_LHU = 6'd15,
    ID_SB = 6'd16, ID_SH = 6'd17, ID_SW = 6'd18,
    ID_ADDI = 6'd19, ID_SLTI = 6'd20, ID_SLTIU = 6'd21, ID_XORI = 6'd22,
    ID_ORI = 6'd23, ID_ANDI = 6'd24,
    ID_SLLI = 6'd25, ID_SRLI = 6'd26, ID_SRAI = 6'd27,
    ID_ADD = 6'd28, ID_SUB = 6'd29, ID_SLL = 6'd30, ID_SLT = 6'd31,
    ID_SLTU = 6'd32, ID_XOR = 6'd33, ID_SRL = 6'd34, ID_SRA = 6'd35,
    ID_OR = 6'd36, ID_AND = 6'd37,
    ID_ECALL = 6'd38, ID_EBREAK = 6'd39,
    ID_CSRRW = 6'd40, ID_CSRRS = 6'd41, ID_CSRRC = 6'd42,
    ID_CSRRWI = 6'd43, ID_CSRRSI = 6'd44, ID_CSRRCI = 6'd45
  } instr_id_t;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_I    = 3'd1,
    FMT_S    = 3'd2,
    FMT_B    = 3'd3,
    FMT_U    = 3'd4,
    FMT_J    = 3'd5,
    FMT_SH   = 3'd6
  } fmt_t;

  typedef struct packed {
    logic        legal;
    instr_id_t   instr_id;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic [31:0] immediate;
    logic [11:0] csr_number;
    logic [31:0] target_address;
  } result_t;

endpackage

@@ hdl/rvid_decode.sv @@
// Combinational decode of one RV32I word into identity, fields and target.
// Depends on rvid_pkg.
module rvid_decode import rvid_pkg::*; (
  input  logic [31:0] instruction,
  input  logic [31:0] fetch_address,
  output result_t     result
);

  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [6:0]  f7;
  instr_id_t   id;
  fmt_t        fmt;
  logic        has_target;
  logic        is_csr;
  logic [31:0] imm;

  assign opcode = instruction[6:0];
  assign f3     = instruction[14:12];
  assign f7     = instruction[31:25];

  always_comb begin
    id         = ID_ILLEGAL;
    fmt        = FMT_NONE;
    has_target = 1'b0;
    is_csr     = 1'b0;
    case (opcode)
      OP_LUI: begin
        id  = ID_LUI;
        fmt = FMT_U;
      end
      OP_AUIPC: begin
        id  = ID_AUIPC;
        fmt = FMT_U;
      end
      OP_JAL: begin
        id         = ID_JAL;
        fmt        = FMT_J;
        has_target = 1'b1;
      end
      OP_JALR: begin
        id  = ID_JALR;
        fmt = FMT_I;
      end
      OP_BRANCH: begin
        fmt        = FMT_B;
        has_target = 1'b1;
        case (f3)
          3'd0:    id = ID_BEQ;
          3'd1:    id = ID_BNE;
          3'd4:    id = ID_BLT;
          3'd5:    id = ID_BGE;
          3'd6:    id = ID_BLTU;
          3'd7:    id = ID_BGEU;
          default: id = ID_ILLEGAL;
        endcase
      end
      OP_LOAD: begin
        fmt = FMT_I;
        case (f3)
          3'd0:    id = ID_LB;
          3'd1:    id = ID_LH;
          3'd2:    id = ID_LW;
          3'd4:    id = ID_LBU;
          3'd5:    id = ID_LHU;
          default: id = ID_ILLEGAL;
        endcase
      end
      OP_STORE: begin
        fmt = FMT_S;
        case (f3)
          3'd0:    id = ID_SB;
          3'd1:    id = ID_SH;
          3'd2:    id = ID_SW;
          default: id = ID_ILLEGAL;
        endcase
      end
      OP_ALUI: begin
        fmt = (f3 inside {3'd1, 3'd5}) ? FMT_SH : FMT_I;
        case (f3)
          3'd0: id = ID_ADDI;
          3'd1: id = ID_SLLI;  // funct7 not checked
          3'd2: id = ID_SLTI;
          3'd3: id = ID_SLTIU;
          3'd4: id = ID_XORI;
          3'd5: begin
            if (f7 == F7_BASE)     id = ID_SRLI;
            else if (f7 == F7_ALT) id = ID_SRAI;
            else                   id = ID_ILLEGAL;
          end
          3'd6:    id = ID_ORI;
          default: id = ID_ANDI;
        endcase
      end
      OP_ALUR: begin
        case (f3)
          3'd0: begin
            if (f7 == F7_BASE)     id = ID_ADD;
            else if (f7 == F7_ALT) id = ID_SUB;
            else                   id = ID_ILLEGAL;
          end
          3'd1: id = ID_SLL;
          3'd2: id = ID_SLT;
          3'd3: id = ID_SLTU;
          3'd4: id = ID_XOR;
          3'd5: begin
            if (f7 == F7_BASE)     id = ID_SRL;
            else if (f7 == F7_ALT) id = ID_SRA;
            else                   id = ID_ILLEGAL;
          end
          3'd6:    id = ID_OR;
          default: id = ID_AND;
        endcase
      end
      OP_SYSTEM: begin
        case (f3)
          3'd0: begin
            if (instruction == WORD_ECALL)       id = ID_ECALL;
            else if (instruction == WORD_EBREAK) id = ID_EBREAK;
            else                                 id = ID_ILLEGAL;
          end
          3'd1:    id = ID_CSRRW;
          3'd2:    id = ID_CSRRS;
          3'd3:    id = ID_CSRRC;
          3'd5:    id = ID_CSRRWI;
          3'd6:    id = ID_CSRRSI;
          3'd7:    id = ID_CSRRCI;
          default: id = ID_ILLEGAL;
        endcase
        is_csr = (f3 != 3'd0) && (f3 != 3'd4);
      end
      default: id = ID_ILLEGAL;
    endcase
  end

  always_comb begin
    case (fmt)
      FMT_I:   imm = {{20{instruction[31]}}, instruction[31:20]};
      FMT_S:   imm = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
      FMT_B:   imm = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                      instruction[11:8], 1'b0};
      FMT_U:   imm = {instruction[31:12], 12'h000};
      FMT_J:   imm = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                      instruction[30:21], 1'b0};
      FMT_SH:  imm = {27'd0, instruction[24:20]};
      default: imm = 32'd0;
    endcase
  end

  always_comb begin
    result = '0;
    if (id != ID_ILLEGAL) begin
      result.legal          = 1'b1;
      result.instr_id       = id;
      result.dest_reg       = instruction[11:7];
      result.src_reg_a      = instruction[19:15];
      result.src_reg_b      = instruction[24:20];
      result.immediate      = imm;
      result.csr_number     = is_csr ? instruction[31:20] : 12'd0;
      result.target_address = has_target ? (fetch_address + imm) : 32'd0;
    end
  end

endmodule

@@ hdl/rv32i_instruction_decoder.sv @@
// Top level of the RV32I instruction decoder: input register, decode, result register.
// Depends on rvid_pkg, rvid_decode and rv32i_instruction_decoder_assert.svh.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_ready  | instruction, fetch_address
//   out     | out_valid/out_ready| legal, instr_id, dest_reg, src_reg_a, src_reg_b,
//           |                    | immediate, csr_number, target_address
//
// One word per cycle while out_ready is high; a word passes input register, then result register.
// Decode and the 32-bit target add sit between the two registers.
// A stall on out backs up through the two stages; in_ready drops only when both are full.
// rst is synchronous and clears the stage valid bits only.
`include "rv32i_instruction_decoder_assert.svh"

module rv32i_instruction_decoder import rvid_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        instruction,
  input  logic [31:0]        fetch_address,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               legal,
  output logic [5:0]         instr_id,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src_reg_a,
  output logic [4:0]         src_reg_b,
  output logic signed [31:0] immediate,
  output logic [11:0]        csr_number,
  output logic [31:0]        target_address
);

  logic        s1_valid;
  logic [31:0] s1_instr;
  logic [31:0] s1_addr;
  logic        s2_valid;
  result_t     s2_result;
  result_t     dec_result;
  logic        s2_load;
  logic        s1_load;

  assign s2_load  = s1_valid && (!s2_valid || out_ready);
  assign in_ready = !s1_valid || s2_load;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_load) begin
      s1_instr <= instruction;
      s1_addr  <= fetch_address;
    end
  end

  rvid_decode u_decode (
    .instruction   (s1_instr),
    .fetch_address (s1_addr),
    .result        (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || out_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_load) begin
      s2_result <= dec_result;
    end
  end

  assign out_valid      = s2_valid;
  assign legal          = s2_result.legal;
  assign instr_id       = s2_result.instr_id;
  assign dest_reg       = s2_result.dest_reg;
  assign src_reg_a      = s2_result.src_reg_a;
  assign src_reg_b      = s2_result.src_reg_b;
  assign immediate      = $signed(s2_result.immediate);
  assign csr_number     = s2_result.csr_number;
  assign target_address = s2_result.target_address;

  `RVID_ASSERT_NOW(a_illegal_zero, clk, rst,
    out_valid && !legal,
    instr_id == 6'd0 && immediate == 32'sd0 && target_address == 32'd0
      && csr_number == 12'd0,
    "illegal word with nonzero result fields")

  `RVID_ASSERT_NOW(a_legal_has_id, clk, rst,
    out_valid && legal, instr_id != 6'd0,
    "legal word without identity")

  `RVID_ASSERT_NEXT(a_stage_advance, clk, rst,
    s2_load, s2_valid,
    "decoded word not captured in result register")

  `RVID_ASSERT_NOW(a_no_drop, clk, rst,
    s1_valid && !s2_load, !in_ready,
    "input accepted while stage one held a word")

endmodule

@@ verif/rv32i_instruction_decoder_tb.sv @@
`timescale 1ns / 1ps
// Testbench for rv32i_instruction_decoder: directed table, then ~1300 random words.
// Checks results against a local model or typed rows. Depends on rvid_pkg and the RTL.
module rv32i_instruction_decoder_tb;
  import rvid_pkg::*;

  localparam int RANDOM_WORDS  = 1300;
  localparam int STALL_LIMIT   = 2000;
  localparam int N_DIRECTED    = 27;

  typedef struct {
    logic [31:0] word;
    logic [31:0] pc;
    bit          typed;
    result_t     want;
  } stim_row_t;

  localparam result_t ALL_ZERO = '0;

  // typed rows: illegal words and the two exact system words
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, ALL_ZERO},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ALL_ZERO},
    '{32'hFFFF_F0B7, 32'h0000_0000, 1'b0, ALL_ZERO},
    '{32'h0000_1017, 32'h0000_4000, 1'b0, ALL_ZERO},
    '{32'h8000_00EF, 32'h0000_0000, 1'b0, ALL_ZERO},
    '{32'h7FFF_F0EF, 32'hFFFF_FFFC, 1'b0, ALL_ZERO},
    '{32'hFFF7_F0E7, 32'h1234_5678, 1'b0, ALL_ZERO},
    '{32'hFE00_0FE3, 32'h0000_0000, 1'b0, ALL_ZERO},
    '{32'h7E00_7FE3, 32'hFFFF_FFFE, 1'b0, ALL_ZERO},
    '{32'h0000_2063, 32'h0000_0100, 1'b1, ALL_ZERO},
    '{32'hFFF1_2283, 32'h0000_0200, 1'b0, ALL_ZERO},
    '{32'h0000_3003, 32'h0000_0204, 1'b1, ALL_ZERO},
    '{32'hFEF0_AFA3, 32'h0000_0208, 1'b0, ALL_ZERO},
    '{32'hFFFF_F023, 32'h0000_020C, 1'b1, ALL_ZERO},
    '{32'h7FF0_0013, 32'h8000_0000, 1'b0, ALL_ZERO},
    '{32'hFFF0_9093, 32'h8000_0004, 1'b0, ALL_ZERO},
    '{32'h0000_5013, 32'h8000_0008, 1'b0, ALL_ZERO},
    '{32'h41F0_5093, 32'h8000_000C, 1'b0, ALL_ZERO},
    '{32'h0200_5093, 32'h8000_0010, 1'b1, ALL_ZERO},
    '{32'h4000_0033, 32'h7FFF_FFFC, 1'b0, ALL_ZERO},
    '{32'hFFFF_FFB3, 32'h7FFF_FFF8, 1'b0, ALL_ZERO},
    '{32'h0200_0033, 32'h7FFF_FFF4, 1'b1, ALL_ZERO},
    '{WORD_ECALL, 32'h0000_1000, 1'b1,
      '{1'b1, ID_ECALL, 5'd0, 5'd0, 5'd0, 32'd0, 12'd0, 32'd0}},
    '{WORD_EBREAK, 32'h0000_1004, 1'b1,
      '{1'b1, ID_EBREAK, 5'd0, 5'd0, 5'd1, 32'd0, 12'd0, 32'd0}},
    '{32'h1020_0073, 32'h0000_1008, 1'b1, ALL_ZERO},
    '{32'h0000_4073, 32'h0000_100C, 1'b1, ALL_ZERO},
    '{32'hFFFF_90F3, 32'h0000_1010, 1'b0, ALL_ZERO}
  };

  localparam logic [6:0] KNOWN_OPS [10] = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH,
                                            OP_LOAD, OP_STORE, OP_ALUI, OP_ALUR, OP_SYSTEM};
  localparam logic [2:0] BRANCH_F3 [6]  = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7};
  localparam logic [2:0] LOAD_F3 [5]    = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd5};
  localparam logic [2:0] ALUI_F3 [6]    = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd6, 3'd7};
  localparam logic [2:0] ALUR_F3 [10]   = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5,
                                            3'd6, 3'd7};
  localparam logic [2:0] CSR_F3 [6]     = '{3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        instruction = '0;
  logic [31:0]        fetch_address = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               legal;
  logic [5:0]         instr_id;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg_a;
  logic [4:0]         src_reg_b;
  logic signed [31:0] immediate;
  logic [11:0]        csr_number;
  logic [31:0]        target_address;

  result_t word_want = '0;
  result_t decoded_q [$];
  logic    idle_on = 1'b1;
  int      errors = 0;
  int      stall_cycles = 0;

  rv32i_instruction_decoder dut (.*);

  always #5 clk = ~clk;

  function automatic result_t decode_word(logic [31:0] w, logic [31:0] pc);
    result_t    r;
    instr_id_t  id;
    fmt_t       fmt;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [31:0] imm;
    logic       has_tgt;
    logic       is_csr;
    r = '0;
    id = ID_ILLEGAL;
    fmt = FMT_NONE;
    f3 = w[14:12];
    f7 = w[31:25];
    imm = '0;
    has_tgt = 1'b0;
    is_csr = 1'b0;
    case (w[6:0])
      OP_LUI: begin
        id = ID_LUI; fmt = FMT_U;
      end
      OP_AUIPC: begin
        id = ID_AUIPC; fmt = FMT_U;
      end
      OP_JAL: begin
        id = ID_JAL; fmt = FMT_J; has_tgt = 1'b1;
      end
      OP_JALR: begin
        id = ID_JALR; fmt = FMT_I;
      end
      OP_BRANCH: begin
        fmt = FMT_B; has_tgt = 1'b1;
        case (f3)
          3'd0: id = ID_BEQ;
          3'd1: id = ID_BNE;
          3'd4: id = ID_BLT;
          3'd5: id = ID_BGE;
          3'd6: id = ID_BLTU;
          3'd7: id = ID_BGEU;
          default: id = ID_ILLEGAL;
        endcase
      end
      OP_LOAD: begin
        fmt = FMT_I;
        case (f3)
          3'd0: id = ID_LB;
          3'd1: id = ID_LH;
          3'd2: id = ID_LW;
          3'd4: id = ID_LBU;
          3'd5: id = ID_LHU;
          default: id = ID_ILLEGAL;
        endcase
      end
      OP_STORE: begin
        fmt = FMT_S;
        case (f3)
          3'd0: id = ID_SB;
          3'd1: id = ID_SH;
          3'd2: id = ID_SW;
          default: id = ID_ILLEGAL;
        endcase
      end
      OP_ALUI: begin
        fmt = (f3 == 3'd1 || f3 == 3'd5) ? FMT_SH : FMT_I;
        case (f3)
          3'd0: id = ID_ADDI;
          3'd1: id = ID_SLLI;
          3'd2: id = ID_SLTI;
          3'd3: id = ID_SLTIU;
          3'd4: id = ID_XORI;
          3'd5: begin
            if (f7 == F7_BASE) id = ID_SRLI;
            else if (f7 == F7_ALT) id = ID_SRAI;
          end
          3'd6: id = ID_ORI;
          default: id = ID_ANDI;
        endcase
      end
      OP_ALUR: begin
        case (f3)
          3'd0: begin
            if (f7 == F7_BASE) id = ID_ADD;
            else if (f7 == F7_ALT) id = ID_SUB;
          end
          3'd1: id = ID_SLL;
          3'd2: id = ID_SLT;
          3'd3: id = ID_SLTU;
          3'd4: id = ID_XOR;
          3'd5: begin
            if (f7 == F7_BASE) id = ID_SRL;
            else if (f7 == F7_ALT) id = ID_SRA;
          end
          3'd6: id = ID_OR;
          default: id = ID_AND;
        endcase
      end
      OP_SYSTEM: begin
        case (f3)
          3'd0: begin
            if (w == WORD_ECALL) id = ID_ECALL;
            else if (w == WORD_EBREAK) id = ID_EBREAK;
          end
          3'd1: id = ID_CSRRW;
          3'd2: id = ID_CSRRS;
          3'd3: id = ID_CSRRC;
          3'd5: id = ID_CSRRWI;
          3'd6: id = ID_CSRRSI;
          3'd7: id = ID_CSRRCI;
          default: id = ID_ILLEGAL;
        endcase
        is_csr = (f3 != 3'd0) && (id != ID_ILLEGAL);
      end
      default: id = ID_ILLEGAL;
    endcase
    if (id == ID_ILLEGAL) return r;
    case (fmt)
      FMT_I:   imm = {{20{w[31]}}, w[31:20]};
      FMT_S:   imm = {{20{w[31]}}, w[31:25], w[11:7]};
      FMT_B:   imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      FMT_U:   imm = {w[31:12], 12'b0};
      FMT_J:   imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      FMT_SH:  imm = {27'b0, w[24:20]};
      default: imm = '0;
    endcase
    r.legal = 1'b1;
    r.instr_id = id;
    r.dest_reg = w[11:7];
    r.src_reg_a = w[19:15];
    r.src_reg_b = w[24:20];
    r.immediate = imm;
    r.csr_number = is_csr ? w[31:20] : 12'd0;
    r.target_address = has_tgt ? pc + imm : 32'd0;
    return r;
  endfunction

  // mostly well-formed words with random content; some noise and broken encodings
  function automatic logic [31:0] make_word();
    logic [31:0] w;
    instr_id_t   id;
    int          pick;
    w = $urandom;
    pick = $urandom_range(99);
    if (pick < 8) return w;
    if (pick < 15) begin
      w[6:0] = KNOWN_OPS[$urandom_range(9)];
      return w;
    end
    id = instr_id_t'($urandom_range(45, 1));
    if (id == ID_ECALL) return WORD_ECALL;
    if (id == ID_EBREAK) return WORD_EBREAK;
    if (id == ID_LUI) w[6:0] = OP_LUI;
    else if (id == ID_AUIPC) w[6:0] = OP_AUIPC;
    else if (id == ID_JAL) w[6:0] = OP_JAL;
    else if (id == ID_JALR) w[6:0] = OP_JALR;
    else if (id <= ID_BGEU) begin
      w[6:0] = OP_BRANCH; w[14:12] = BRANCH_F3[id - ID_BEQ];
    end else if (id <= ID_LHU) begin
      w[6:0] = OP_LOAD; w[14:12] = LOAD_F3[id - ID_LB];
    end else if (id <= ID_SW) begin
      w[6:0] = OP_STORE; w[14:12] = 3'(id - ID_SB);
    end else if (id <= ID_ANDI) begin
      w[6:0] = OP_ALUI; w[14:12] = ALUI_F3[id - ID_ADDI];
    end else if (id == ID_SLLI) begin
      w[6:0] = OP_ALUI; w[14:12] = 3'd1;
    end else if (id == ID_SRLI || id == ID_SRAI) begin
      w[6:0] = OP_ALUI; w[14:12] = 3'd5;
      w[31:25] = (id == ID_SRAI) ? F7_ALT : F7_BASE;
    end else if (id <= ID_AND) begin
      w[6:0] = OP_ALUR; w[14:12] = ALUR_F3[id - ID_ADD];
      if (id == ID_SUB || id == ID_SRA) w[31:25] = F7_ALT;
      else if (id == ID_ADD || id == ID_SRL || $urandom_range(1)) w[31:25] = F7_BASE;
    end else begin
      w[6:0] = OP_SYSTEM; w[14:12] = CSR_F3[id - ID_CSRRW];
    end
    return w;
  endfunction

  function automatic logic [31:0] make_pc();
    logic [31:0] pc;
    pc = $urandom;
    case ($urandom_range(9))
      0: pc[31:8] = '1;
      1: pc[31:8] = '0;
      default: ;
    endcase
    return pc;
  endfunction

  task automatic send_word(input logic [31:0] w, input logic [31:0] pc, input result_t want);
    while (idle_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    instruction <= w;
    fetch_address <= pc;
    word_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 19) : 1'b1;
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("result word with nothing outstanding");
          errors++;
        end else begin
          want = decoded_q.pop_front();
          check_field("legal", 32'(want.legal), 32'(legal));
          check_field("instr_id", 32'(want.instr_id), 32'(instr_id));
          check_field("dest_reg", 32'(want.dest_reg), 32'(dest_reg));
          check_field("src_reg_a", 32'(want.src_reg_a), 32'(src_reg_a));
          check_field("src_reg_b", 32'(want.src_reg_b), 32'(src_reg_b));
          check_field("immediate", want.immediate, immediate);
          check_field("csr_number", 32'(want.csr_number), 32'(csr_number));
          check_field("target_address", want.target_address, target_address);
        end
      end
      if (in_valid && in_ready) decoded_q.push_back(word_want);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] w;
    logic [31:0] pc;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].pc,
                directed_rows[i].typed ? directed_rows[i].want :
                decode_word(directed_rows[i].word, directed_rows[i].pc));
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // back-to-back stretch on both sides
      if (n == 400) idle_on <= 1'b0;
      if (n == 700) idle_on <= 1'b1;
      w = make_word();
      pc = make_pc();
      send_word(w, pc, decode_word(w, pc));
    end
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/rvid_pkg.sv
hdl/rvid_decode.sv
hdl/rv32i_instruction_decoder.sv
verif/rv32i_instruction_decoder_tb.sv
